// ===== rtl/spar_pkg.sv =====
// spar_pkg: shared types, codes and constants of the sprite pose remap core
// no dependencies; used by the top level, spar_front and spar_back
`default_nettype none

package spar_pkg;

  // configuration
  localparam int CFG_W        = 13;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 3;
  localparam int MAX_DIM_DEF  = 4096;
  localparam logic [CFG_W-1:0] FRAME_DIM_RST = 13'd1024;

  // register index as decoded from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // queue depths
  localparam int CMD_Q_DEPTH = 4;
  localparam int RES_Q_DEPTH = 4;

  // field widths
  localparam int POS_W   = 12;
  localparam int AMT_W   = 16;
  localparam int COLOR_W = 24;
  localparam int OUT_W   = 16;

  // op codes
  localparam logic [1:0] OP_POSE   = 2'd0;
  localparam logic [1:0] OP_PIXEL  = 2'd1;
  localparam logic [1:0] OP_COMMIT = 2'd2;

  // pose command keys
  localparam logic [2:0] KEY_UP       = 3'd0;
  localparam logic [2:0] KEY_DOWN     = 3'd1;
  localparam logic [2:0] KEY_LEFT     = 3'd2;
  localparam logic [2:0] KEY_RIGHT    = 3'd3;
  localparam logic [2:0] KEY_CW       = 3'd4;
  localparam logic [2:0] KEY_CCW      = 3'd5;
  localparam logic [2:0] KEY_MIRROR_X = 3'd6;
  localparam logic [2:0] KEY_MIRROR_Y = 3'd7;

  // classified request kinds
  typedef enum logic [2:0] {
    KIND_VMOVE       = 3'd0,
    KIND_HMOVE       = 3'd1,
    KIND_TURN        = 3'd2,
    KIND_MIRROR_ROWS = 3'd3,
    KIND_MIRROR_COLS = 3'd4,
    KIND_PIXEL       = 3'd5,
    KIND_COMMIT      = 3'd6
  } kind_t;

  // classified request, front to back
  typedef struct packed {
    kind_t                     kind;
    logic signed [AMT_W:0]     amount;  // screen-direction move, already negated
    logic [1:0]                turns;   // clockwise quarter turns mod four
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          col;
    logic [COLOR_W-1:0]        color;
  } item_t;

  // remapped pixel
  typedef struct packed {
    logic signed [OUT_W-1:0]   new_row;
    logic signed [OUT_W-1:0]   new_col;
    logic [COLOR_W-1:0]        color;
    logic                      out_of_frame;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/sprite_pose_accumulate_and_remap_core.sv =====
// sprite_pose_accumulate_and_remap_core: top level of the sprite pose remap core
// depends on spar_pkg, spar_fifo, spar_front and spar_back
//
//  channel   | direction | handshake                 | carries
//  ----------+-----------+---------------------------+----------------------------------
//  request   | in        | push / full               | op, command_key, command_amount,
//            |           |                           | pixel_row, pixel_col, pixel_color
//  result    | out       | pop / empty               | new_row, new_col, out_color,
//            |           |                           | out_of_frame
//  config    | in        | psel, penable, pwrite     | frame_width at 0x0,
//            |           | (pready tied high)        | frame_height at 0x4
//
// one request per clock sustained while full is low; a pixel result reaches the result
// ports through the request queue, the remap stage, then the result queue
// reset (rst, synchronous) clears the pose, both queues and the remap stage, and sets
// both frame dimensions to 1024
// full rises only when the request queue fills; pose requests ahead of the next pixel
// keep draining while the remap stage waits on a full result queue
`default_nettype none

module sprite_pose_accumulate_and_remap_core #(
  parameter int MAX_DIM = spar_pkg::MAX_DIM_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [spar_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [spar_pkg::DATA_W-1:0]          pwdata,
  output logic      [spar_pkg::DATA_W-1:0]          prdata,
  output logic                                      pready,
  // request side
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic [1:0]                           op,
  input  wire logic [2:0]                           command_key,
  input  wire logic signed [spar_pkg::AMT_W-1:0]    command_amount,
  input  wire logic [spar_pkg::POS_W-1:0]           pixel_row,
  input  wire logic [spar_pkg::POS_W-1:0]           pixel_col,
  input  wire logic [spar_pkg::COLOR_W-1:0]         pixel_color,
  // result side
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic signed [spar_pkg::OUT_W-1:0]         new_row,
  output logic signed [spar_pkg::OUT_W-1:0]         new_col,
  output logic [spar_pkg::COLOR_W-1:0]              out_color,
  output logic                                      out_of_frame
);

  localparam int ITEM_W = $bits(spar_pkg::item_t);
  localparam int RES_W  = $bits(spar_pkg::res_t);

  // frame size registers
  logic [spar_pkg::CFG_W-1:0] frame_width, frame_width_next;
  logic [spar_pkg::CFG_W-1:0] frame_height, frame_height_next;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // word-aligned decode: paddr[2] picks the register
  always_comb begin
    frame_width_next  = frame_width;
    frame_height_next = frame_height;
    if (cfg_wr) begin
      unique case (paddr[2])
        spar_pkg::REG_FRAME_WIDTH:  frame_width_next  = pwdata[spar_pkg::CFG_W-1:0];
        spar_pkg::REG_FRAME_HEIGHT: frame_height_next = pwdata[spar_pkg::CFG_W-1:0];
        default:                    frame_width_next  = frame_width;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      spar_pkg::REG_FRAME_WIDTH:  prdata = spar_pkg::DATA_W'(frame_width);
      spar_pkg::REG_FRAME_HEIGHT: prdata = spar_pkg::DATA_W'(frame_height);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= spar_pkg::FRAME_DIM_RST;
      frame_height <= spar_pkg::FRAME_DIM_RST;
    end else begin
      frame_width  <= frame_width_next;
      frame_height <= frame_height_next;
    end
  end

  // front end: classify and queue requests
  spar_pkg::item_t fr_item, q_item;
  logic            q_push, q_full, q_empty, q_pop;

  spar_front u_front (
    .push           (push),
    .full           (full),
    .op             (op),
    .command_key    (command_key),
    .command_amount (command_amount),
    .pixel_row      (pixel_row),
    .pixel_col      (pixel_col),
    .pixel_color    (pixel_color),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (fr_item)
  );

  spar_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (spar_pkg::CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .wr_en (q_push),
    .din   (fr_item),
    .rd_en (q_pop),
    .dout  (q_item),
    .full  (q_full),
    .empty (q_empty)
  );

  // back end: pose update and pixel remap
  spar_pkg::res_t be_res, o_res;
  logic           o_push, o_full;

  spar_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (!q_empty),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .o_full       (o_full),
    .o_push       (o_push),
    .o_res        (be_res)
  );

  // result queue decouples the remap stage from the consumer
  spar_fifo #(
    .WIDTH (RES_W),
    .DEPTH (spar_pkg::RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr_en (o_push),
    .din   (be_res),
    .rd_en (pop),
    .dout  (o_res),
    .full  (o_full),
    .empty (empty)
  );

  assign new_row      = o_res.new_row;
  assign new_col      = o_res.new_col;
  assign out_color    = o_res.color;
  assign out_of_frame = o_res.out_of_frame;

endmodule

`default_nettype wire

// ===== rtl/spar_fifo.sv =====
// spar_fifo: small register-based first-in first-out queue
// depends on nothing; used for the request queue and the result queue
`default_nettype none

module spar_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] dout,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic             do_wr, do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_wr) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_next = count + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spar_front.sv =====
// spar_front: accepts input requests and classifies them for the back end
// depends on spar_pkg
`default_nettype none

module spar_front (
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic [1:0]                           op,
  input  wire logic [2:0]                           command_key,
  input  wire logic signed [spar_pkg::AMT_W-1:0]    command_amount,
  input  wire logic [spar_pkg::POS_W-1:0]           pixel_row,
  input  wire logic [spar_pkg::POS_W-1:0]           pixel_col,
  input  wire logic [spar_pkg::COLOR_W-1:0]         pixel_color,
  input  wire logic                                 q_full,
  output logic                                      q_push,
  output spar_pkg::item_t                           q_item
);

  logic                             keep;
  logic signed [spar_pkg::AMT_W:0]  amt_ext;

  assign amt_ext = {command_amount[spar_pkg::AMT_W-1], command_amount};

  always_comb begin
    keep          = 1'b1;
    q_item.kind   = spar_pkg::KIND_PIXEL;
    q_item.amount = amt_ext;
    q_item.turns  = command_amount[1:0];
    q_item.row    = pixel_row;
    q_item.col    = pixel_col;
    q_item.color  = pixel_color;
    unique case (op)
      spar_pkg::OP_POSE: begin
        unique case (command_key)
          spar_pkg::KEY_UP: begin
            q_item.kind = spar_pkg::KIND_VMOVE;
          end
          spar_pkg::KEY_DOWN: begin
            q_item.kind   = spar_pkg::KIND_VMOVE;
            q_item.amount = -amt_ext;
          end
          spar_pkg::KEY_LEFT: begin
            q_item.kind   = spar_pkg::KIND_HMOVE;
            q_item.amount = -amt_ext;
          end
          spar_pkg::KEY_RIGHT: begin
            q_item.kind = spar_pkg::KIND_HMOVE;
          end
          spar_pkg::KEY_CW: begin
            q_item.kind = spar_pkg::KIND_TURN;
          end
          spar_pkg::KEY_CCW: begin
            // counter-clockwise turns as clockwise modulo four
            q_item.kind  = spar_pkg::KIND_TURN;
            q_item.turns = 2'b00 - command_amount[1:0];
          end
          spar_pkg::KEY_MIRROR_X: begin
            q_item.kind = spar_pkg::KIND_MIRROR_ROWS;
          end
          default: begin
            q_item.kind = spar_pkg::KIND_MIRROR_COLS;
          end
        endcase
      end
      spar_pkg::OP_PIXEL: begin
        q_item.kind = spar_pkg::KIND_PIXEL;
      end
      spar_pkg::OP_COMMIT: begin
        q_item.kind = spar_pkg::KIND_COMMIT;
      end
      default: begin
        // unused op: taken and dropped
        keep = 1'b0;
      end
    endcase
  end

  assign full   = q_full;
  assign q_push = push && !q_full && keep;

endmodule

`default_nettype wire

// ===== rtl/spar_back.sv =====
// spar_back: pose register update and two-step pixel remap
// depends on spar_pkg; feeds the result queue
`default_nettype none

module spar_back #(
  parameter int MAX_DIM = spar_pkg::MAX_DIM_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  input  wire spar_pkg::item_t              q_item,
  output logic                              q_pop,
  input  wire logic [spar_pkg::CFG_W-1:0]   frame_width,
  input  wire logic [spar_pkg::CFG_W-1:0]   frame_height,
  input  wire logic                         o_full,
  output logic                              o_push,
  output spar_pkg::res_t                    o_res
);

  localparam int AW    = spar_pkg::AMT_W;
  localparam int OFS_W = AW + 2;             // offset sums and shifted positions
  localparam int CW    = OFS_W + 1;          // remap arithmetic
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (DIM_W > spar_pkg::CFG_W) ? DIM_W : spar_pkg::CFG_W;
  localparam logic signed [OFS_W-1:0] OFS_MAX = OFS_W'(32767);
  localparam logic signed [OFS_W-1:0] OFS_MIN = -OFS_W'(32767);
  localparam logic signed [CW-1:0]    OUT_MAX = CW'(32767);
  localparam logic signed [CW-1:0]    OUT_MIN = -CW'(32768);

  function automatic logic signed [AW-1:0] sat_ofs(input logic signed [OFS_W-1:0] v);
    logic signed [AW-1:0] s;
    if (v > OFS_MAX) begin
      s = OFS_MAX[AW-1:0];
    end else if (v < OFS_MIN) begin
      s = OFS_MIN[AW-1:0];
    end else begin
      s = v[AW-1:0];
    end
    return s;
  endfunction

  function automatic logic signed [spar_pkg::OUT_W-1:0] sat_out(input logic signed [CW-1:0] v);
    logic signed [spar_pkg::OUT_W-1:0] s;
    if (v > OUT_MAX) begin
      s = OUT_MAX[spar_pkg::OUT_W-1:0];
    end else if (v < OUT_MIN) begin
      s = OUT_MIN[spar_pkg::OUT_W-1:0];
    end else begin
      s = v[spar_pkg::OUT_W-1:0];
    end
    return s;
  endfunction

  function automatic logic [CMP_W-1:0] dim_of(input logic [spar_pkg::CFG_W-1:0] reg_val);
    logic [CMP_W-1:0] d;
    d = CMP_W'(reg_val);
    if (d == '0) begin
      d = CMP_W'(1);
    end else if (d > CMP_W'(MAX_DIM)) begin
      d = CMP_W'(MAX_DIM);
    end
    return d;
  endfunction

  // pose state
  logic signed [AW-1:0] up_offset, up_offset_next;
  logic signed [AW-1:0] right_offset, right_offset_next;
  logic [1:0]           quarter_turns, quarter_turns_next;
  logic                 mirror_rows, mirror_rows_next;
  logic                 mirror_cols, mirror_cols_next;

  // remap stage
  logic                         b_valid, b_valid_next;
  logic signed [OFS_W-1:0]      b_r, b_c;
  logic [1:0]                   b_qt;
  logic                         b_mr, b_mc;
  logic [spar_pkg::COLOR_W-1:0] b_color;

  logic                     b_ready, b_load;
  logic signed [AW:0]       vv, hh;
  logic signed [OFS_W-1:0]  du, dr, up_sum, right_sum;
  logic signed [OFS_W-1:0]  pix_r, pix_c;

  // pop pose requests freely; a pixel waits for the remap stage
  assign b_ready = !b_valid || !o_full;
  assign q_pop   = q_valid && ((q_item.kind != spar_pkg::KIND_PIXEL) || b_ready);
  assign b_load  = q_pop && (q_item.kind == spar_pkg::KIND_PIXEL);
  assign o_push  = b_valid && !o_full;

  // move deltas, with the mirror applied in screen terms
  assign vv = mirror_rows ? -q_item.amount : q_item.amount;
  assign hh = mirror_cols ? -q_item.amount : q_item.amount;

  always_comb begin
    du = '0;
    dr = '0;
    case (q_item.kind)
      spar_pkg::KIND_VMOVE: begin
        case (quarter_turns)
          2'd0:    du =  {vv[AW], vv};
          2'd1:    dr = -{vv[AW], vv};
          2'd2:    du = -{vv[AW], vv};
          default: dr =  {vv[AW], vv};
        endcase
      end
      spar_pkg::KIND_HMOVE: begin
        case (quarter_turns)
          2'd0:    dr =  {hh[AW], hh};
          2'd1:    du =  {hh[AW], hh};
          2'd2:    dr = -{hh[AW], hh};
          default: du = -{hh[AW], hh};
        endcase
      end
      default: begin
        du = '0;
        dr = '0;
      end
    endcase
  end

  assign up_sum    = {{2{up_offset[AW-1]}}, up_offset} + du;
  assign right_sum = {{2{right_offset[AW-1]}}, right_offset} + dr;

  always_comb begin
    up_offset_next     = up_offset;
    right_offset_next  = right_offset;
    quarter_turns_next = quarter_turns;
    mirror_rows_next   = mirror_rows;
    mirror_cols_next   = mirror_cols;
    if (q_pop) begin
      case (q_item.kind)
        spar_pkg::KIND_VMOVE, spar_pkg::KIND_HMOVE: begin
          up_offset_next    = sat_ofs(up_sum);
          right_offset_next = sat_ofs(right_sum);
        end
        spar_pkg::KIND_TURN: begin
          if (mirror_rows || mirror_cols) begin
            // a turn under a mirror runs the other way; a half turn swaps the mirror
            case (q_item.turns)
              2'd1:    quarter_turns_next = quarter_turns + 2'd3;
              2'd2: begin
                mirror_rows_next = !mirror_rows;
                mirror_cols_next = !mirror_cols;
              end
              2'd3:    quarter_turns_next = quarter_turns + 2'd1;
              default: quarter_turns_next = quarter_turns;
            endcase
          end else begin
            quarter_turns_next = quarter_turns + q_item.turns;
          end
        end
        spar_pkg::KIND_MIRROR_ROWS: begin
          if (mirror_cols) begin
            // double mirror folds into a half turn
            mirror_cols_next   = 1'b0;
            quarter_turns_next = quarter_turns + 2'd2;
          end else begin
            mirror_rows_next = !mirror_rows;
          end
        end
        spar_pkg::KIND_MIRROR_COLS: begin
          if (mirror_rows) begin
            mirror_rows_next   = 1'b0;
            quarter_turns_next = quarter_turns + 2'd2;
          end else begin
            mirror_cols_next = !mirror_cols;
          end
        end
        spar_pkg::KIND_COMMIT: begin
          up_offset_next     = '0;
          right_offset_next  = '0;
          quarter_turns_next = '0;
          mirror_rows_next   = 1'b0;
          mirror_cols_next   = 1'b0;
        end
        default: begin
          up_offset_next = up_offset;
        end
      endcase
    end
  end

  // offset step of a pixel
  assign pix_r = OFS_W'(q_item.row) - {{2{up_offset[AW-1]}}, up_offset};
  assign pix_c = OFS_W'(q_item.col) + {{2{right_offset[AW-1]}}, right_offset};

  always_comb begin
    b_valid_next = b_valid;
    if (b_load) begin
      b_valid_next = 1'b1;
    end else if (o_push) begin
      b_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_offset     <= '0;
      right_offset  <= '0;
      quarter_turns <= '0;
      mirror_rows   <= 1'b0;
      mirror_cols   <= 1'b0;
      b_valid       <= 1'b0;
    end else begin
      up_offset     <= up_offset_next;
      right_offset  <= right_offset_next;
      quarter_turns <= quarter_turns_next;
      mirror_rows   <= mirror_rows_next;
      mirror_cols   <= mirror_cols_next;
      b_valid       <= b_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_r     <= pix_r;
      b_c     <= pix_c;
      b_qt    <= quarter_turns;
      b_mr    <= mirror_rows;
      b_mc    <= mirror_cols;
      b_color <= q_item.color;
    end
  end

  // rotate / mirror step
  logic signed [CW-1:0] w, h, wl, hl, r, c;
  logic signed [CW-1:0] wl_r, wl_c, hl_r, hl_c, nr, nc;

  assign w    = CW'(dim_of(frame_width));
  assign h    = CW'(dim_of(frame_height));
  assign wl   = w - CW'(1);
  assign hl   = h - CW'(1);
  assign r    = {b_r[OFS_W-1], b_r};
  assign c    = {b_c[OFS_W-1], b_c};
  assign wl_r = wl - r;
  assign wl_c = wl - c;
  assign hl_r = hl - r;
  assign hl_c = hl - c;

  always_comb begin
    nr = r;
    nc = c;
    case (b_qt)
      2'd1: begin
        if (b_mr) begin
          nc = wl_r; nr = hl_c;
        end else if (b_mc) begin
          nc = r;    nr = c;
        end else begin
          nc = wl_r; nr = c;
        end
      end
      2'd2: begin
        if (b_mr) begin
          nc = wl_c;
        end else if (b_mc) begin
          nr = hl_r;
        end else begin
          nc = wl_c; nr = hl_r;
        end
      end
      2'd3: begin
        if (b_mr) begin
          nc = r;    nr = c;
        end else if (b_mc) begin
          nc = wl_r; nr = hl_c;
        end else begin
          nc = r;    nr = hl_c;
        end
      end
      default: begin
        if (b_mr) begin
          nr = hl_r;
        end else if (b_mc) begin
          nc = wl_c;
        end
      end
    endcase
  end

  assign o_res.new_row      = sat_out(nr);
  assign o_res.new_col      = sat_out(nc);
  assign o_res.color        = b_color;
  assign o_res.out_of_frame = (nr < 0) || (nr >= h) || (nc < 0) || (nc >= w);

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// testbench: self-checking bench for the sprite pose remap core
// needs spar_pkg and sprite_pose_accumulate_and_remap_core; drives requests, checks remapped pixels
`timescale 1ns / 100ps

module testbench;

  localparam int LATENCY    = 3;
  localparam int IDLE_PCT   = 7;
  localparam int LONG_HOLD  = 80;
  localparam int OFFSET_MAX = 32767;
  localparam int MAX_DIM    = spar_pkg::MAX_DIM_DEF;

  // unused op code, must be ignored by the core
  localparam logic [1:0] OP_SPARE = 2'd3;

  // register byte addresses
  localparam logic [spar_pkg::ADDR_W-1:0] ADDR_FRAME_WIDTH  = 3'h0;
  localparam logic [spar_pkg::ADDR_W-1:0] ADDR_FRAME_HEIGHT = 3'h4;

  typedef struct {
    logic [1:0]                         op;
    logic [2:0]                         key;
    logic signed [spar_pkg::AMT_W-1:0]  amount;
    logic [spar_pkg::POS_W-1:0]         row;
    logic [spar_pkg::POS_W-1:0]         col;
    logic [spar_pkg::COLOR_W-1:0]       color;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                psel    = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite  = 1'b0;
  logic [spar_pkg::ADDR_W-1:0]         paddr   = '0;
  logic [spar_pkg::DATA_W-1:0]         pwdata  = '0;
  logic [spar_pkg::DATA_W-1:0]         prdata;
  logic                                pready;

  logic                                push           = 1'b0;
  logic                                full;
  logic [1:0]                          op             = '0;
  logic [2:0]                          command_key    = '0;
  logic signed [spar_pkg::AMT_W-1:0]   command_amount = '0;
  logic [spar_pkg::POS_W-1:0]          pixel_row      = '0;
  logic [spar_pkg::POS_W-1:0]          pixel_col      = '0;
  logic [spar_pkg::COLOR_W-1:0]        pixel_color    = '0;

  logic                                empty;
  logic                                pop = 1'b0;
  logic signed [spar_pkg::OUT_W-1:0]   new_row;
  logic signed [spar_pkg::OUT_W-1:0]   new_col;
  logic [spar_pkg::COLOR_W-1:0]        out_color;
  logic                                out_of_frame;

  // requests waiting to be offered, and remapped pixels still owed
  request_t          pending_req_q[$];
  spar_pkg::res_t    remap_expect_q[$];

  // shadow pose and frame registers
  int          up_off      = 0;
  int          right_off   = 0;
  logic [1:0]  turns       = 2'd0;
  logic        mir_rows    = 1'b0;
  logic        mir_cols    = 1'b0;
  logic [12:0] frame_w_cfg = spar_pkg::FRAME_DIM_RST;
  logic [12:0] frame_h_cfg = spar_pkg::FRAME_DIM_RST;

  int          err_count = 0;
  logic        quiet_in  = 1'b0;
  logic        quiet_out = 1'b0;
  logic        want_hold = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;

  sprite_pose_accumulate_and_remap_core #(.MAX_DIM(MAX_DIM)) dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .push           (push),
    .full           (full),
    .op             (op),
    .command_key    (command_key),
    .command_amount (command_amount),
    .pixel_row      (pixel_row),
    .pixel_col      (pixel_col),
    .pixel_color    (pixel_color),
    .empty          (empty),
    .pop            (pop),
    .new_row        (new_row),
    .new_col        (new_col),
    .out_color      (out_color),
    .out_of_frame   (out_of_frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- pose model

  function automatic int sat_offset(input int v);
    if (v > OFFSET_MAX) return OFFSET_MAX;
    if (v < -OFFSET_MAX) return -OFFSET_MAX;
    return v;
  endfunction

  function automatic logic signed [spar_pkg::OUT_W-1:0] sat_word(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[spar_pkg::OUT_W-1:0];
  endfunction

  // register value clamped to a usable frame size
  function automatic int frame_dim(input logic [12:0] cfg_val);
    if (cfg_val == 13'd0) return 1;
    if (int'(cfg_val) > MAX_DIM) return MAX_DIM;
    return int'(cfg_val);
  endfunction

  // positive amount moves up on screen, seen through the current pose
  task automatic move_vertical(input int v);
    if (turns != 2'd0) begin
      if (mir_rows) v = -v;
      case (turns)
        2'd1:    right_off = sat_offset(right_off - v);
        2'd2:    up_off    = sat_offset(up_off - v);
        default: right_off = sat_offset(right_off + v);
      endcase
    end else if (mir_rows) begin
      up_off = sat_offset(up_off - v);
    end else begin
      up_off = sat_offset(up_off + v);
    end
  endtask

  // positive amount moves right on screen
  task automatic move_horizontal(input int v);
    if (turns != 2'd0) begin
      if (mir_cols) v = -v;
      case (turns)
        2'd1:    up_off    = sat_offset(up_off + v);
        2'd2:    right_off = sat_offset(right_off - v);
        default: up_off    = sat_offset(up_off - v);
      endcase
    end else if (mir_cols) begin
      right_off = sat_offset(right_off - v);
    end else begin
      right_off = sat_offset(right_off + v);
    end
  endtask

  // a mirrored pose turns the other way; a half turn swaps the mirror
  task automatic add_turns(input logic [1:0] t);
    if (mir_rows || mir_cols) begin
      case (t)
        2'd1: turns = turns + 2'd3;
        2'd2: begin
          mir_rows = !mir_rows;
          mir_cols = !mir_cols;
        end
        2'd3: turns = turns + 2'd1;
        default: ;
      endcase
    end else begin
      turns = turns + t;
    end
  endtask

  // both mirrors together are a half turn
  task automatic fold_mirrors();
    if (mir_rows && mir_cols) begin
      mir_rows = 1'b0;
      mir_cols = 1'b0;
      turns    = turns + 2'd2;
    end
  endtask

  // update the shadow pose for one request, and owe a result for a pixel
  task automatic apply_request(input request_t rq);
    spar_pkg::res_t res;
    int   w, h, r, c, nr, nc;
    case (rq.op)
      spar_pkg::OP_POSE: begin
        case (rq.key)
          spar_pkg::KEY_UP:       move_vertical(int'(rq.amount));
          spar_pkg::KEY_DOWN:     move_vertical(-int'(rq.amount));
          spar_pkg::KEY_LEFT:     move_horizontal(-int'(rq.amount));
          spar_pkg::KEY_RIGHT:    move_horizontal(int'(rq.amount));
          spar_pkg::KEY_CW:       add_turns(rq.amount[1:0]);
          spar_pkg::KEY_CCW:      add_turns(2'd0 - rq.amount[1:0]);
          spar_pkg::KEY_MIRROR_X: begin
            mir_rows = !mir_rows;
            fold_mirrors();
          end
          default: begin
            mir_cols = !mir_cols;
            fold_mirrors();
          end
        endcase
      end
      spar_pkg::OP_COMMIT: begin
        up_off    = 0;
        right_off = 0;
        turns     = 2'd0;
        mir_rows  = 1'b0;
        mir_cols  = 1'b0;
      end
      spar_pkg::OP_PIXEL: begin
        w  = frame_dim(frame_w_cfg);
        h  = frame_dim(frame_h_cfg);
        r  = int'(rq.row) - up_off;
        c  = int'(rq.col) + right_off;
        nr = r;
        nc = c;
        case (turns)
          2'd1: begin
            if (mir_rows) begin
              nc = w - 1 - r;
              nr = h - 1 - c;
            end else if (mir_cols) begin
              nc = r;
              nr = c;
            end else begin
              nc = w - 1 - r;
              nr = c;
            end
          end
          2'd2: begin
            if (mir_rows) begin
              nc = w - 1 - c;
            end else if (mir_cols) begin
              nr = h - 1 - r;
            end else begin
              nc = w - 1 - c;
              nr = h - 1 - r;
            end
          end
          2'd3: begin
            if (mir_rows) begin
              nc = r;
              nr = c;
            end else if (mir_cols) begin
              nc = w - 1 - r;
              nr = h - 1 - c;
            end else begin
              nc = r;
              nr = h - 1 - c;
            end
          end
          default: begin
            if (mir_rows) nr = h - 1 - r;
            else if (mir_cols) nc = w - 1 - c;
          end
        endcase
        // frame test is on the unsaturated position
        res.out_of_frame = (nr < 0) || (nr >= h) || (nc < 0) || (nc >= w);
        res.new_row      = sat_word(nr);
        res.new_col      = sat_word(nc);
        res.color        = rq.color;
        remap_expect_q.push_back(res);
      end
      default: ;  // spare op leaves the pose alone
    endcase
  endtask

  // ---------------------------------------------------------------- driver

  // the head of the pending queue is on the ports while push is high
  always @(posedge clk) begin : driver
    logic offer;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        apply_request(pending_req_q[0]);
        pending_req_q.delete(0);
      end
      offer = (pending_req_q.size() != 0) &&
              (quiet_in || ($urandom_range(99) >= IDLE_PCT));
      if (offer) begin
        op             <= pending_req_q[0].op;
        command_key    <= pending_req_q[0].key;
        command_amount <= pending_req_q[0].amount;
        pixel_row      <= pending_req_q[0].row;
        pixel_col      <= pending_req_q[0].col;
        pixel_color    <= pending_req_q[0].color;
      end
      push <= offer;
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    spar_pkg::res_t want;
    logic pop_next;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (remap_expect_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, got row %0d col %0d",
                   $time, new_row, new_col);
        end else begin
          want = remap_expect_q.pop_front();
          check_field("new_row", int'($signed(want.new_row)), int'($signed(new_row)));
          check_field("new_col", int'($signed(want.new_col)), int'($signed(new_col)));
          check_field("out_color", int'(want.color), int'(out_color));
          check_field("out_of_frame", int'(want.out_of_frame), int'(out_of_frame));
        end
      end
      // one long hold-off so that the core backs up and raises full
      if (hold_left > 0) begin
        hold_left--;
        pop_next = 1'b0;
      end else if (want_hold && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
        pop_next  = 1'b0;
      end else begin
        pop_next = quiet_out || ($urandom_range(99) >= IDLE_PCT);
      end
      pop <= pop_next;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_req(input logic [1:0] o, input logic [2:0] k, input int amt,
                           input int r, input int c, input int colr);
    request_t rq;
    rq.op     = o;
    rq.key    = k;
    rq.amount = amt[spar_pkg::AMT_W-1:0];
    rq.row    = r[spar_pkg::POS_W-1:0];
    rq.col    = c[spar_pkg::POS_W-1:0];
    rq.color  = colr[spar_pkg::COLOR_W-1:0];
    pending_req_q.push_back(rq);
  endtask

  task automatic reg_write(input logic [spar_pkg::ADDR_W-1:0] addr,
                           input logic [spar_pkg::DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_FRAME_WIDTH) frame_w_cfg = data[12:0];
    else frame_h_cfg = data[12:0];
  endtask

  task automatic set_frame(input logic [spar_pkg::DATA_W-1:0] w,
                           input logic [spar_pkg::DATA_W-1:0] h);
    reg_write(ADDR_FRAME_WIDTH, w);
    reg_write(ADDR_FRAME_HEIGHT, h);
  endtask

  // all requests taken, all results in, then let trailing pose requests settle
  task automatic wait_idle();
    while (pending_req_q.size() != 0 || remap_expect_q.size() != 0 || push)
      @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  function automatic int rand_amount();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return $urandom_range(64) - 32;
    if (sel < 85) return $urandom_range(65535);
    case ($urandom_range(4))
      0:       return 32767;
      1:       return -32768;
      2:       return -1;
      3:       return 0;
      default: return 1;
    endcase
  endfunction

  // random pose requests and pixels, with occasional commits and spare ops
  task automatic queue_random(input int n);
    int done_cnt, sel, w, h, r, c;
    done_cnt = 0;
    w = frame_dim(frame_w_cfg);
    h = frame_dim(frame_h_cfg);
    while (done_cnt < n) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        queue_req(spar_pkg::OP_POSE, 3'($urandom_range(7)), rand_amount(),
                  $urandom_range(4095), $urandom_range(4095), $urandom_range(24'hFFFFFF));
        done_cnt++;
      end else if (sel < 90) begin
        if ($urandom_range(99) < 75) begin
          r = $urandom_range(h - 1);
          c = $urandom_range(w - 1);
        end else begin
          r = $urandom_range(4095);
          c = $urandom_range(4095);
        end
        queue_req(spar_pkg::OP_PIXEL, 3'($urandom_range(7)), $urandom_range(65535), r, c,
                  $urandom_range(24'hFFFFFF));
        done_cnt++;
      end else if (sel < 96) begin
        queue_req(spar_pkg::OP_COMMIT, 3'($urandom_range(7)), $urandom_range(65535),
                  $urandom_range(4095), $urandom_range(4095), $urandom_range(24'hFFFFFF));
        done_cnt++;
      end else begin
        queue_req(OP_SPARE, 3'($urandom_range(7)), $urandom_range(65535),
                  $urandom_range(4095), $urandom_range(4095), $urandom_range(24'hFFFFFF));
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed, default 1024 square frame
    queue_req(spar_pkg::OP_PIXEL, spar_pkg::KEY_UP, 0, 0, 0, 0);
    queue_req(spar_pkg::OP_PIXEL, spar_pkg::KEY_UP, 0, 4095, 4095, 24'hFFFFFF);
    // offset saturation
    queue_req(spar_pkg::OP_POSE, spar_pkg::KEY_UP, 32767, 0, 0, 0);
    queue_req(spar_pkg::OP_POSE, spar_pkg::KEY_UP, 32767, 0, 0, 0);
    queue_req(spar_pkg::OP_PIXEL, spar_pkg::KEY_UP, 0, 0, 0, 24'h123456);
    queue_req(spar_pkg::OP_POSE, spar_pkg::KEY_DOWN, -32768, 0, 0, 0);
    queue_req(spar_pkg::OP_POSE, spar_pkg::KEY_RIGHT, 32767, 0, 0, 0);
    queue_req(spar_pkg::OP_POSE, spar_pkg::KEY_RIGHT, 100, 0, 0, 0);
    // position saturation, high then low
    queue_req(spar_pkg::OP_PIXEL, spar_pkg::KEY_UP, 0, 4095, 4095, 24'hABCDEF);
    queue_req(spar_pkg::OP_POSE, spar_pkg::KEY_CW, 1, 0, 0, 0);
    queue_req(spar_pkg::OP_POSE, spar_pkg::KEY_MIRROR_X, 0, 0, 0, 0);
    queue_req(spar_pkg::OP_PIXEL, spar_pkg::KEY_UP, 0, 0, 4095, 24'h00FF00);
    queue_req(spar_pkg::OP_COMMIT, spar_pkg::KEY_UP, 0, 0, 0, 0);
    // every turn and mirror, including the fold and negative counts
    queue_req(spar_pkg::OP_POSE, spar_pkg::KEY_CW, 1, 0, 0, 0);
    queue_req(spar_pkg::OP_PIXEL, spar_pkg::KEY_UP, 0, 10, 20, 24'h0000FF);
    queue_req(spar_pkg::OP_POSE, spar_pkg::KEY_MIRROR_X, 0, 0, 0, 0);
    queue_req(spar_pkg::OP_PIXEL, spar_pkg::KEY_UP, 0, 10, 20, 24'hFF0000);
    queue_req(spar_pkg::OP_POSE, spar_pkg::KEY_MIRROR_Y, 0, 0, 0, 0);
    queue_req(spar_pkg::OP_PIXEL, spar_pkg::KEY_UP, 0, 10, 20, 24'h808080);
    queue_req(spar_pkg::OP_POSE, spar_pkg::KEY_CCW, -1, 0, 0, 0);
    queue_req(spar_pkg::OP_POSE, spar_pkg::KEY_CW, -2, 0, 0, 0);
    queue_req(spar_pkg::OP_POSE, spar_pkg::KEY_LEFT, 5, 0, 0, 0);
    queue_req(spar_pkg::OP_PIXEL, spar_pkg::KEY_UP, 0, 300, 700, 24'h7F7F7F);
    // spare op carries no result and keeps the pose
    queue_req(OP_SPARE, spar_pkg::KEY_MIRROR_Y, -1, 4095, 4095, 24'hFFFFFF);
    queue_req(spar_pkg::OP_COMMIT, spar_pkg::KEY_UP, 0, 0, 0, 0);
    queue_req(spar_pkg::OP_POSE, spar_pkg::KEY_MIRROR_Y, 0, 0, 0, 0);
    queue_req(spar_pkg::OP_POSE, spar_pkg::KEY_CW, 3, 0, 0, 0);
    queue_req(spar_pkg::OP_POSE, spar_pkg::KEY_UP, -40, 0, 0, 0);
    queue_req(spar_pkg::OP_PIXEL, spar_pkg::KEY_UP, 0, 1023, 0, 24'h010203);
    wait_idle();

    // largest square frame
    set_frame(32'd4096, 32'd4096);
    queue_random(90);
    wait_idle();

    // smallest frame
    set_frame(32'd1, 32'd1);
    queue_random(60);
    wait_idle();

    // small frame while the receiver holds off
    set_frame(32'd17, 32'd17);
    want_hold = 1'b1;
    queue_random(100);
    wait_idle();

    // out of range sizes, junk in the unused upper bits
    set_frame(32'hA5A5_0000, 32'h5A5A_1FFF);
    queue_random(80);
    wait_idle();

    // non-square frame, no idling on either side
    set_frame(32'd640, 32'd480);
    quiet_in  = 1'b1;
    quiet_out = 1'b1;
    queue_random(100);
    wait_idle();
    quiet_in  = 1'b0;
    quiet_out = 1'b0;

    set_frame(32'd4097, 32'hFFFF_E001);
    queue_random(60);
    wait_idle();

    set_frame(32'd1024, 32'd1024);
    queue_random(60);
    wait_idle();

    repeat (LATENCY + 5) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
